// File: rtl/core/ffha_pkg.sv
`timescale 1ns / 1ps
package ffha_pkg;
	localparam int HEAP_BYTES_DEF = 65536;
	localparam int WORD_BYTES     = 4;
	localparam int ALIGN_BYTES    = 8;
	localparam int HANDLE_BYTES   = 2 * WORD_BYTES;
	localparam int NODE_BYTES     = 2 * WORD_BYTES;

	localparam int OP_W   = 2;
	localparam int REQ_W  = 16;
	localparam int ADDR_W = 17;
	localparam int DATA_W = 17;
	localparam int OFF_W  = 18;

	localparam logic [OP_W-1:0] OP_INIT   = 2'd0;
	localparam logic [OP_W-1:0] OP_ALLOC  = 2'd1;
	localparam logic [OP_W-1:0] OP_FREE   = 2'd2;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FAIL = 1'b1;

	localparam logic [ADDR_W-1:0] HEAP_SIZE_RST = 17'd65536;
endpackage

// File: rtl/core/ffha_if.sv
`timescale 1ns / 1ps
interface ffha_req_if;
	logic                          valid;
	logic                          ready;
	logic [ffha_pkg::OP_W-1:0]     operation;
	logic [ffha_pkg::REQ_W-1:0]    request_size;
	logic [ffha_pkg::ADDR_W-1:0]   block_address;
	modport source(output valid, operation, request_size, block_address, input ready);
	modport sink(input valid, operation, request_size, block_address, output ready);
endinterface

interface ffha_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          status;
	logic [ffha_pkg::ADDR_W-1:0]   result_address;
	modport source(output valid, status, result_address, input ready);
	modport sink(input valid, status, result_address, output ready);
endinterface

// File: rtl/core/ffha_ram.sv
`timescale 1ns / 1ps
module ffha_ram #(
	parameter int Width = 17,
	parameter int Depth = 16384
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(Depth)-1:0] wr_addr,
	input  logic [Width-1:0]         wr_data,
	input  logic [$clog2(Depth)-1:0] rd_addr,
	output logic [Width-1:0]         rd_data
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

// File: rtl/core/first_fit_heap_allocator.sv
`timescale 1ns / 1ps
// Channel  | Dir | Word contents                               | Handshake
// req      | in  | operation, request_size, block_address      | valid/ready
// rsp      | out | status, result_address                      | valid/ready
// cfg      | in  | heap_size                                   | cfg_wr_en
//
// One word is processed at a time; req.ready is high only while idle.
// Init writes the first free node; allocate reads each free-list node it visits
// and then splits or unlinks; free walks to its place, then links and merges.
// Each step is bound by the single read and single write port of the word store.
// arst_n clears the list head and heap limit; the word store is not cleared.
// A result waits in rsp until taken, and no new word is accepted meanwhile.
module first_fit_heap_allocator #(
	parameter int HeapBytes = ffha_pkg::HEAP_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [ffha_pkg::ADDR_W-1:0] cfg_wr_data,
	ffha_req_if.sink                    req,
	ffha_rsp_if.source                  rsp
);
	import ffha_pkg::*;

	localparam int StoreWords = HeapBytes / WORD_BYTES;
	localparam int IdxW       = $clog2(StoreWords);
	localparam int StepW      = $clog2(StoreWords + 1);

	typedef enum logic [4:0] {
		ST_IDLE, ST_INIT1, ST_INIT2,
		ST_A_CHK, ST_A_RD1, ST_A_RD2, ST_A_EVAL,
		ST_A_S1, ST_A_S2, ST_A_S3, ST_A_S4,
		ST_F_CHK, ST_F_STEP, ST_F_B0, ST_F_B1, ST_F_B2, ST_F_B3,
		ST_F_WL, ST_F_P1, ST_F_P2, ST_DONE
	} state_t;

	state_t              state_q;
	logic [ADDR_W-1:0]   heap_size_q, heap_limit_q, first_free_q;
	logic [ADDR_W-1:0]   need_q, cur_q, prev_q, nxt_q, sz_q, nx_q, blink_q;
	logic [DATA_W-1:0]   bsz_q;
	logic [OFF_W-1:0]    start_q;
	logic [StepW-1:0]    steps_q;
	logic                status_q, out_valid_q, rd_oob_q;
	logic [ADDR_W-1:0]   result_q;

	logic [OFF_W-1:0]    rd_off, wr_off;
	logic [DATA_W-1:0]   wr_data, ram_q, rd;
	logic                wr_en;
	logic [OFF_W-1:0]    rest_off, cur_hdr, prev_end;
	logic [OFF_W-1:0]    need_hdr;
	logic [DATA_W:0]     merged;
	logic [OFF_W-1:0]    req_need, free_start;
	logic                fits, whole, free_bad, walk_end;

	assign rd       = rd_oob_q ? '0 : ram_q;
	assign need_hdr = OFF_W'(need_q) + OFF_W'(WORD_BYTES);
	assign cur_hdr  = OFF_W'(cur_q) + OFF_W'(WORD_BYTES);
	assign rest_off = cur_hdr + OFF_W'(need_q);
	assign prev_end = OFF_W'(prev_q) + OFF_W'(rd);
	assign merged   = {1'b0, bsz_q} + {1'b0, rd};
	assign fits     = OFF_W'(sz_q) >= need_hdr;
	assign whole    = OFF_W'(sz_q) < need_hdr + OFF_W'(NODE_BYTES);
	assign walk_end = (cur_q == '0) || (steps_q == StepW'(StoreWords));

	// Round the request up to the alignment; a zero request becomes one unit.
	always_comb begin
		req_need = (OFF_W'(req.request_size) + OFF_W'(ALIGN_BYTES - 1))
			& ~OFF_W'(ALIGN_BYTES - 1);
		if (req_need == '0) begin
			req_need = OFF_W'(ALIGN_BYTES);
		end
	end

	assign free_start = OFF_W'(req.block_address) - OFF_W'(WORD_BYTES);
	assign free_bad   = (req.block_address < ADDR_W'(HANDLE_BYTES + WORD_BYTES))
		|| (free_start > OFF_W'(heap_limit_q))
		|| (req.block_address[1:0] != 2'b00);

	always_comb begin
		rd_off  = OFF_W'(cur_q);
		wr_en   = 1'b0;
		wr_off  = '0;
		wr_data = '0;
		case (state_q)
			ST_INIT1: begin
				wr_en   = 1'b1;
				wr_off  = OFF_W'(HANDLE_BYTES);
				wr_data = heap_limit_q - DATA_W'(HANDLE_BYTES);
			end
			ST_INIT2: begin
				wr_en  = 1'b1;
				wr_off = OFF_W'(HANDLE_BYTES + WORD_BYTES);
			end
			ST_A_RD1: rd_off = cur_hdr;
			ST_A_EVAL: begin
				if (fits && whole && prev_q != '0) begin
					wr_en   = 1'b1;
					wr_off  = OFF_W'(prev_q) + OFF_W'(WORD_BYTES);
					wr_data = nx_q;
				end
			end
			ST_A_S1: begin
				wr_en   = 1'b1;
				wr_off  = rest_off;
				wr_data = DATA_W'(OFF_W'(sz_q) - need_hdr);
			end
			ST_A_S2: begin
				wr_en   = 1'b1;
				wr_off  = rest_off + OFF_W'(WORD_BYTES);
				wr_data = nx_q;
			end
			ST_A_S3: begin
				wr_en   = 1'b1;
				wr_off  = OFF_W'(cur_q);
				wr_data = DATA_W'(need_hdr);
			end
			ST_A_S4: begin
				wr_en   = 1'b1;
				wr_off  = OFF_W'(prev_q) + OFF_W'(WORD_BYTES);
				wr_data = DATA_W'(rest_off);
			end
			ST_F_CHK: rd_off = cur_hdr;
			ST_F_B0: rd_off = start_q;
			ST_F_B1: rd_off = OFF_W'(nxt_q);
			ST_F_B2: begin
				rd_off = OFF_W'(nxt_q) + OFF_W'(WORD_BYTES);
				if (start_q + OFF_W'(bsz_q) == OFF_W'(nxt_q)) begin
					wr_en   = 1'b1;
					wr_off  = start_q;
					wr_data = DATA_W'(merged);
				end
			end
			ST_F_WL: begin
				rd_off  = OFF_W'(prev_q);
				wr_en   = 1'b1;
				wr_off  = start_q + OFF_W'(WORD_BYTES);
				wr_data = blink_q;
			end
			ST_F_P1: begin
				wr_en = 1'b1;
				if (start_q == prev_end) begin
					wr_off  = OFF_W'(prev_q);
					wr_data = DATA_W'(merged);
				end else begin
					wr_off  = OFF_W'(prev_q) + OFF_W'(WORD_BYTES);
					wr_data = DATA_W'(start_q);
				end
			end
			ST_F_P2: begin
				wr_en   = 1'b1;
				wr_off  = OFF_W'(prev_q) + OFF_W'(WORD_BYTES);
				wr_data = blink_q;
			end
			default: ;
		endcase
	end

	ffha_ram #(
		.Width(DATA_W),
		.Depth(StoreWords)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en && (wr_off < OFF_W'(HeapBytes))),
		.wr_addr(wr_off[IdxW+1:2]),
		.wr_data(wr_data),
		.rd_addr(rd_off[IdxW+1:2]),
		.rd_data(ram_q)
	);

	assign req.ready          = (state_q == ST_IDLE);
	assign rsp.valid          = out_valid_q;
	assign rsp.status         = status_q;
	assign rsp.result_address = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			heap_size_q  <= HEAP_SIZE_RST;
			heap_limit_q <= '0;
			first_free_q <= '0;
			out_valid_q  <= 1'b0;
			status_q     <= STATUS_FAIL;
			result_q     <= '0;
			rd_oob_q     <= 1'b0;
			steps_q      <= '0;
		end else begin
			rd_oob_q <= rd_off >= OFF_W'(HeapBytes);
			if (cfg_wr_en) begin
				heap_size_q <= cfg_wr_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						status_q <= STATUS_FAIL;
						result_q <= '0;
						cur_q    <= first_free_q;
						prev_q   <= '0;
						nxt_q    <= '0;
						steps_q  <= '0;
						need_q   <= ADDR_W'(req_need);
						start_q  <= free_start;
						case (req.operation)
							OP_INIT: begin
								if (heap_size_q <= ADDR_W'(HANDLE_BYTES + NODE_BYTES)
									|| heap_size_q > ADDR_W'(HeapBytes)) begin
									out_valid_q <= 1'b1;
									state_q     <= ST_DONE;
								end else begin
									heap_limit_q <= heap_size_q;
									first_free_q <= ADDR_W'(HANDLE_BYTES);
									state_q      <= ST_INIT1;
								end
							end
							OP_ALLOC: state_q <= ST_A_CHK;
							OP_FREE: begin
								if (free_bad) begin
									out_valid_q <= 1'b1;
									state_q     <= ST_DONE;
								end else begin
									state_q <= ST_F_CHK;
								end
							end
							default: begin
								out_valid_q <= 1'b1;
								state_q     <= ST_DONE;
							end
						endcase
					end
				end
				ST_INIT1: state_q <= ST_INIT2;
				ST_INIT2: begin
					status_q    <= STATUS_OK;
					out_valid_q <= 1'b1;
					state_q     <= ST_DONE;
				end
				ST_A_CHK: begin
					if (walk_end) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_DONE;
					end else begin
						state_q <= ST_A_RD1;
					end
				end
				ST_A_RD1: begin
					sz_q    <= rd;
					state_q <= ST_A_RD2;
				end
				ST_A_RD2: begin
					nx_q    <= rd;
					state_q <= ST_A_EVAL;
				end
				ST_A_EVAL: begin
					if (fits) begin
						status_q <= STATUS_OK;
						result_q <= ADDR_W'(cur_hdr);
						if (whole) begin
							if (prev_q == '0) begin
								first_free_q <= nx_q;
							end
							out_valid_q <= 1'b1;
							state_q     <= ST_DONE;
						end else begin
							state_q <= ST_A_S1;
						end
					end else begin
						prev_q  <= cur_q;
						cur_q   <= nx_q;
						steps_q <= steps_q + 1'b1;
						state_q <= ST_A_CHK;
					end
				end
				ST_A_S1: state_q <= ST_A_S2;
				ST_A_S2: state_q <= ST_A_S3;
				ST_A_S3: begin
					if (prev_q == '0) begin
						first_free_q <= ADDR_W'(rest_off);
						out_valid_q  <= 1'b1;
						state_q      <= ST_DONE;
					end else begin
						state_q <= ST_A_S4;
					end
				end
				ST_A_S4: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_DONE;
				end
				// Walk to the first free block at or after the freed one.
				ST_F_CHK: begin
					if (walk_end) begin
						state_q <= ST_F_B0;
					end else if (OFF_W'(cur_q) < start_q) begin
						prev_q  <= cur_q;
						state_q <= ST_F_STEP;
					end else begin
						nxt_q   <= cur_q;
						state_q <= ST_F_B0;
					end
				end
				ST_F_STEP: begin
					cur_q   <= rd;
					steps_q <= steps_q + 1'b1;
					state_q <= ST_F_CHK;
				end
				ST_F_B0: state_q <= ST_F_B1;
				ST_F_B1: begin
					bsz_q <= rd;
					if (nxt_q != '0) begin
						state_q <= ST_F_B2;
					end else begin
						blink_q <= '0;
						state_q <= ST_F_WL;
					end
				end
				ST_F_B2: begin
					if (start_q + OFF_W'(bsz_q) == OFF_W'(nxt_q)) begin
						bsz_q   <= DATA_W'(merged);
						state_q <= ST_F_B3;
					end else begin
						blink_q <= nxt_q;
						state_q <= ST_F_WL;
					end
				end
				ST_F_B3: begin
					blink_q <= rd;
					state_q <= ST_F_WL;
				end
				ST_F_WL: begin
					if (prev_q != '0) begin
						state_q <= ST_F_P1;
					end else begin
						first_free_q <= ADDR_W'(start_q);
						status_q     <= STATUS_OK;
						out_valid_q  <= 1'b1;
						state_q      <= ST_DONE;
					end
				end
				ST_F_P1: begin
					status_q <= STATUS_OK;
					if (start_q == prev_end) begin
						state_q <= ST_F_P2;
					end else begin
						out_valid_q <= 1'b1;
						state_q     <= ST_DONE;
					end
				end
				ST_F_P2: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_DONE;
				end
				ST_DONE: begin
					if (rsp.ready) begin
						out_valid_q <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: rtl/core/ffha_checker.sv
`timescale 1ns / 1ps
module ffha_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        status,
	input logic [ffha_pkg::ADDR_W-1:0] result_address
);
	import ffha_pkg::*;

	// A held result must not drop before it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// Only one word is in flight, so input and output never overlap.
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input open while result pending");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready stayed high after accept");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_FAIL |-> result_address == '0)
		else $error("failed result carries an address");
endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (req.valid),
	.in_ready      (req.ready),
	.out_valid     (rsp.valid),
	.out_ready     (rsp.ready),
	.status        (rsp.status),
	.result_address(rsp.result_address)
);
